// File: design/rfsf_pkg.sv
// shared types and constants of the resonant four stage filter
// no dependencies; imported by resonant_four_stage_filter_core
package rfsf_pkg;

   // control port geometry
   localparam int CSR_AW = 5;

   // register indexes (paddr[4:2])
   localparam logic [2:0] REG_CUTOFF_BASE    = 3'd0;
   localparam logic [2:0] REG_RESONANCE_BASE = 3'd1;
   localparam logic [2:0] REG_CUTOFF_DEPTH   = 3'd2;
   localparam logic [2:0] REG_RES_DEPTH      = 3'd3;
   localparam logic [2:0] REG_RATE_SCALE     = 3'd4;
   localparam logic [2:0] REG_HIGH_PASS      = 3'd5;
   localparam logic [2:0] REG_FOUR_POLE      = 3'd6;

   // fixed point limits, 16 fraction bits
   localparam logic [18:0] RATE_RESET = 19'd65536;
   localparam logic [16:0] UNITY      = 17'd65536;
   localparam logic [15:0] CUT2_MAX   = 16'd65529;
   localparam int          FB_LIMIT   = 131072;
   localparam int          OUT_LIMIT  = 327680;

   // stored stages of one voice and channel
   typedef struct packed {
      logic signed [31:0] s1;
      logic signed [31:0] s2;
      logic signed [31:0] s3;
      logic signed [31:0] s4;
   } stage_set_type;

endpackage

// File: design/resonant_four_stage_filter_core.sv
// resonant four stage filter core: sequencer, shared multiplier, root and divide units
// depends on rfsf_pkg
//
// Usage
// - req channel: one item per valid/ready handshake. action 0 filters sample_in of
//   (voice, channel); action 1 zeroes the stored stages of both channels of voice.
// - rsp channel: exactly one item per request, carrying sample_out, voice_out and
//   channel_out, in request order.
// - csr port: APB-style registers at byte address 4*index, pready always high.
//   The user must write registers only while no item is in flight; the block does not enforce this.
// - path: a filter item steps through the sequencer states CB to UPD, then FIN, before it
//   shows on rsp; a clear or a voice outside the configured range goes straight to FIN.
// - one item at a time: the next item is taken only when the sequencer is idle again.
//   Each filter item runs the 16 step square root and the 43 step restoring divider,
//   plus ten passes through the single 36x20 multiplier.
// - the result sits in an output register; the next item is taken while it waits.
//   If the receiver stalls and the output register is still full when the next
//   result is ready, the sequencer holds in its last state until the register frees.
// - reset: synchronous, active high; clears registers to their defaults and marks
//   every stored stage entry as zero through per entry valid bits (no sweep needed).
//
module resonant_four_stage_filter_core #(
   parameter int VOICES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_action,
   input  logic [3:0]                   req_voice,
   input  logic                         req_channel,
   input  logic signed [23:0]           req_sample_in,
   input  logic signed [23:0]           req_cutoff_cv,
   input  logic signed [23:0]           req_resonance_cv,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [19:0]           rsp_sample_out,
   output logic [3:0]                   rsp_voice_out,
   output logic                         rsp_channel_out,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [rfsf_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import rfsf_pkg::*;

   localparam int ENTRIES = 2 * VOICES;
   localparam int VW      = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int IW      = VW + 1;

   // sequencer codes
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CB    = 4'd1;
   localparam logic [3:0] ST_CMOD  = 4'd2;
   localparam logic [3:0] ST_RMOD  = 4'd3;
   localparam logic [3:0] ST_RATE  = 4'd4;
   localparam logic [3:0] ST_CLAMP = 4'd5;
   localparam logic [3:0] ST_SQRT  = 4'd6;
   localparam logic [3:0] ST_DIVI  = 4'd7;
   localparam logic [3:0] ST_DIV   = 4'd8;
   localparam logic [3:0] ST_FB    = 4'd9;
   localparam logic [3:0] ST_PLO   = 4'd10;
   localparam logic [3:0] ST_PHI   = 4'd11;
   localparam logic [3:0] ST_PSUM  = 4'd12;
   localparam logic [3:0] ST_UPD   = 4'd13;
   localparam logic [3:0] ST_FIN   = 4'd14;

   function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
      logic signed [31:0] r;
      if (v > 41'sh0007FFFFFFF) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -41'sh00080000000) begin
         r = -32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // configuration registers
   logic [16:0] cb_ff, rb_ff, cmd_ff, rmd_ff;
   logic [18:0] rate_ff;
   logic        hp_ff, fp_ff;

   // sequencer and item registers
   logic [3:0]          state_ff, state_in;
   logic [5:0]          cnt_ff;
   logic                work_ff;
   logic [IW-1:0]       idx_ff;
   logic [3:0]          voice_ff;
   logic                chan_ff;
   logic signed [23:0]  x_ff, ccv_ff, rcv_ff;

   // stage storage
   stage_set_type       mem [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff;
   stage_set_type       rd_ff;
   logic                rd_valid_ff;
   logic signed [31:0]  s1_ff, s2_ff, s3_ff, s4_ff;

   // arithmetic registers
   logic signed [55:0]  prod_ff;
   logic signed [39:0]  acc_ff;
   logic signed [26:0]  c2sum_ff, res_ff;
   logic [32:0]         sq_v_ff, sq_r_ff, sq_bit_ff;
   logic [16:0]         cut_ff, den_ff;
   logic [16:0]         rem_ff;
   logic [42:0]         quo_ff;
   logic                neg_ff;
   logic signed [31:0]  fb_ff;
   logic signed [18:0]  p_ff;

   // output register
   logic                rsp_valid_ff;
   logic signed [19:0]  rsp_sample_ff;
   logic [3:0]          rsp_voice_ff;
   logic                rsp_chan_ff;

   // request side decode
   logic [6:0]          voice_wide;
   logic                voice_ok;
   logic [IW-1:0]       req_idx;
   logic                accept;

   assign voice_wide = 7'(req_voice);
   assign voice_ok   = voice_wide < 7'(VOICES);
   assign req_idx    = {voice_wide[VW-1:0], req_channel};
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;

   // shared multiplier operand select
   logic signed [35:0]  mul_a;
   logic signed [19:0]  mul_b;
   logic signed [32:0]  diff12;
   logic signed [34:0]  drive;
   logic signed [39:0]  prod_sh;

   assign diff12  = 33'(s1_ff) - 33'(s2_ff);
   assign prod_sh = 40'(prod_ff >>> 16);

   always_comb begin
      case (cnt_ff[2:1])
         2'd0:    drive = 35'(x_ff) - 35'(s1_ff) + 35'(p_ff);
         2'd1:    drive = 35'(s1_ff) - 35'(s2_ff);
         2'd2:    drive = 35'(s2_ff) - 35'(s3_ff);
         default: drive = 35'(s3_ff) - 35'(s4_ff);
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_CB: begin
            mul_a = 36'($signed({1'b0, cb_ff}));
            mul_b = 20'($signed({1'b0, cb_ff}));
         end
         ST_CMOD: begin
            mul_a = 36'(ccv_ff);
            mul_b = 20'($signed({1'b0, cmd_ff}));
         end
         ST_RMOD: begin
            mul_a = 36'(rcv_ff);
            mul_b = 20'($signed({1'b0, rmd_ff}));
         end
         ST_RATE: begin
            mul_a = 36'(c2sum_ff);
            mul_b = $signed({1'b0, rate_ff});
         end
         ST_PLO: begin
            mul_a = 36'(diff12);
            mul_b = 20'($signed({1'b0, fb_ff[15:0]}));
         end
         ST_PHI: begin
            mul_a = 36'(diff12);
            mul_b = 20'($signed(fb_ff[31:16]));
         end
         ST_UPD: begin
            mul_a = 36'(drive);
            mul_b = 20'($signed({1'b0, cut_ff}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // cutoff squared clamp
   logic [15:0] c2_clamped;
   always_comb begin
      if (prod_sh < 40'sd0) begin
         c2_clamped = '0;
      end else if (prod_sh > 40'(CUT2_MAX)) begin
         c2_clamped = CUT2_MAX;
      end else begin
         c2_clamped = prod_sh[15:0];
      end
   end

   // root step and divide step
   logic [32:0] sq_sum;
   logic [17:0] div_trial;
   logic        div_take;
   assign sq_sum    = sq_r_ff + sq_bit_ff;
   assign div_trial = {rem_ff, quo_ff[42]};
   assign div_take  = div_trial >= {1'b0, den_ff};

   // feedback gain from the saturated quotient
   logic signed [31:0] q_sat;
   logic signed [40:0] fb_sum;
   always_comb begin
      if (!neg_ff) begin
         q_sat = (quo_ff > 43'h0007FFFFFFF) ? 32'sh7FFFFFFF : $signed(quo_ff[31:0]);
      end else begin
         q_sat = (quo_ff >= 43'h00080000000) ? -32'sh80000000 : -$signed(quo_ff[31:0]);
      end
      fb_sum = 41'(res_ff) + 41'(q_sat);
   end

   // feedback product, high half plus floored low half, clamped
   logic signed [55:0] p_total;
   logic signed [18:0] p_clamped;
   always_comb begin
      p_total = prod_ff + 56'(acc_ff);
      if (p_total > 56'(FB_LIMIT)) begin
         p_clamped = 19'(FB_LIMIT);
      end else if (p_total < -56'(FB_LIMIT)) begin
         p_clamped = -19'(FB_LIMIT);
      end else begin
         p_clamped = p_total[18:0];
      end
   end

   // stage update and output tap
   logic signed [31:0] cur_stage, new_stage, tap;
   logic signed [33:0] out_raw;
   logic signed [19:0] out_clamped;
   always_comb begin
      case (cnt_ff[2:1])
         2'd0:    cur_stage = s1_ff;
         2'd1:    cur_stage = s2_ff;
         2'd2:    cur_stage = s3_ff;
         default: cur_stage = s4_ff;
      endcase
      new_stage = sat32(41'(cur_stage) + 41'(prod_sh));
      tap       = fp_ff ? s4_ff : s2_ff;
      out_raw   = hp_ff ? (34'(x_ff) - 34'(tap)) : 34'(tap);
      if (!work_ff) begin
         out_clamped = '0;
      end else if (out_raw > 34'(OUT_LIMIT)) begin
         out_clamped = 20'(OUT_LIMIT);
      end else if (out_raw < -34'(OUT_LIMIT)) begin
         out_clamped = -20'(OUT_LIMIT);
      end else begin
         out_clamped = out_raw[19:0];
      end
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) begin
            state_in = (!req_action && voice_ok) ? ST_CB : ST_FIN;
         end
         ST_CB:    state_in = ST_CMOD;
         ST_CMOD:  state_in = ST_RMOD;
         ST_RMOD:  state_in = ST_RATE;
         ST_RATE:  state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_SQRT;
         ST_SQRT:  if (cnt_ff == 6'd15) begin
            state_in = ST_DIVI;
         end
         ST_DIVI:  state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == 6'd42) begin
            state_in = ST_FB;
         end
         ST_FB:    state_in = ST_PLO;
         ST_PLO:   state_in = ST_PHI;
         ST_PHI:   state_in = ST_PSUM;
         ST_PSUM:  state_in = ST_UPD;
         ST_UPD:   if (cnt_ff == 6'd7) begin
            state_in = ST_FIN;
         end
         ST_FIN:   if (out_free) begin
            state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SQRT || state_ff == ST_DIV || state_ff == ST_UPD) begin
            cnt_ff <= (state_in == state_ff) ? cnt_ff + 6'd1 : '0;
         end else begin
            cnt_ff <= '0;
         end
         if (accept && req_action && voice_ok) begin
            valid_ff[{voice_wide[VW-1:0], 1'b0} +: 2] <= 2'b00;
         end
         if (state_ff == ST_FIN && out_free && work_ff) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         if (state_ff == ST_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // stage memory, registered read at acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[req_idx];
      end
      if (state_ff == ST_FIN && out_free && work_ff) begin
         mem[idx_ff] <= '{s1: s1_ff, s2: s2_ff, s3: s3_ff, s4: s4_ff};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         work_ff     <= !req_action && voice_ok;
         idx_ff      <= req_idx;
         voice_ff    <= req_voice;
         chan_ff     <= req_channel;
         x_ff        <= req_sample_in;
         ccv_ff      <= req_cutoff_cv;
         rcv_ff      <= req_resonance_cv;
         rd_valid_ff <= valid_ff[req_idx];
      end
      case (state_ff)
         ST_CB: begin
            s1_ff <= rd_valid_ff ? rd_ff.s1 : '0;
            s2_ff <= rd_valid_ff ? rd_ff.s2 : '0;
            s3_ff <= rd_valid_ff ? rd_ff.s3 : '0;
            s4_ff <= rd_valid_ff ? rd_ff.s4 : '0;
         end
         ST_CMOD: acc_ff <= prod_sh;
         ST_RMOD: c2sum_ff <= 27'(acc_ff + prod_sh);
         ST_RATE: res_ff <= 27'(40'($signed({1'b0, rb_ff})) + prod_sh);
         ST_CLAMP: begin
            sq_v_ff   <= {1'b0, c2_clamped, 16'b0};
            sq_r_ff   <= '0;
            sq_bit_ff <= 33'h040000000;
         end
         ST_SQRT: begin
            if (sq_v_ff >= sq_sum) begin
               sq_v_ff <= sq_v_ff - sq_sum;
               sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_ff <= sq_r_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         ST_DIVI: begin
            cut_ff <= sq_r_ff[16:0];
            den_ff <= UNITY - sq_r_ff[16:0];
            rem_ff <= '0;
            neg_ff <= res_ff < 27'sd0;
            // dividend is the magnitude of res times 2^16, fed in msb first
            quo_ff <= {(res_ff < 27'sd0) ? 27'(-res_ff) : 27'(res_ff), 16'b0};
         end
         ST_DIV: begin
            rem_ff <= div_take ? 17'(div_trial - {1'b0, den_ff}) : div_trial[16:0];
            quo_ff <= {quo_ff[41:0], div_take};
         end
         ST_FB:   fb_ff <= sat32(fb_sum);
         ST_PHI:  acc_ff <= prod_sh;
         ST_PSUM: p_ff <= p_clamped;
         ST_UPD: if (cnt_ff[0]) begin
            case (cnt_ff[2:1])
               2'd0:    s1_ff <= new_stage;
               2'd1:    s2_ff <= new_stage;
               2'd2:    s3_ff <= new_stage;
               default: s4_ff <= new_stage;
            endcase
         end
         ST_FIN: if (out_free) begin
            rsp_sample_ff <= out_clamped;
            rsp_voice_ff  <= voice_ff;
            rsp_chan_ff   <= chan_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_voice_out   = rsp_voice_ff;
   assign rsp_channel_out = rsp_chan_ff;

   // register file
   logic [2:0] csr_index;
   logic       csr_write;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cb_ff   <= '0;
         rb_ff   <= '0;
         cmd_ff  <= '0;
         rmd_ff  <= '0;
         rate_ff <= RATE_RESET;
         hp_ff   <= 1'b0;
         fp_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_CUTOFF_BASE:    cb_ff   <= csr_pwdata[16:0];
            REG_RESONANCE_BASE: rb_ff   <= csr_pwdata[16:0];
            REG_CUTOFF_DEPTH:   cmd_ff  <= csr_pwdata[16:0];
            REG_RES_DEPTH:      rmd_ff  <= csr_pwdata[16:0];
            REG_RATE_SCALE:     rate_ff <= csr_pwdata[18:0];
            REG_HIGH_PASS:      hp_ff   <= csr_pwdata[0];
            REG_FOUR_POLE:      fp_ff   <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CUTOFF_BASE:    csr_prdata = 32'(cb_ff);
         REG_RESONANCE_BASE: csr_prdata = 32'(rb_ff);
         REG_CUTOFF_DEPTH:   csr_prdata = 32'(cmd_ff);
         REG_RES_DEPTH:      csr_prdata = 32'(rmd_ff);
         REG_RATE_SCALE:     csr_prdata = 32'(rate_ff);
         REG_HIGH_PASS:      csr_prdata = 32'(hp_ff);
         REG_FOUR_POLE:      csr_prdata = 32'(fp_ff);
         default:            csr_prdata = '0;
      endcase
   end

`ifndef SYNTHESIS
   // a result never leaves the output range
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_out <= 20'sd327680 && rsp_sample_out >= -20'sd327680))
      else $error("sample_out beyond limit");

   // an accepted item blocks the input until it is finished
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready right after acceptance");

   // root result keeps the divisor at four or more
   a_cut_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVI) |-> (sq_r_ff <= 33'd65532))
      else $error("cutoff root out of range");

   // divider remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff && den_ff >= 17'd4))
      else $error("divider remainder out of range");

   // a finished result is loaded only when the output register can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample_out)))
      else $error("pending result overwritten");
`endif

endmodule

// File: test/resonant_four_stage_filter_core_tb.sv
// testbench of resonant_four_stage_filter_core: directed table, then random filter traffic
// depends on rfsf_pkg and design/resonant_four_stage_filter_core.sv
`timescale 1ns / 100ps

module resonant_four_stage_filter_core_tb;
   import rfsf_pkg::*;

   localparam int          VOICE_COUNT  = 16;
   localparam int          RANDOM_ITEMS = 2000;
   localparam int          PHASES       = 8;
   localparam int          STALL_LIMIT  = 6000;
   localparam int          DRAIN_CYCLES = 100;
   localparam logic [2:0]  REG_SPARE    = 3'd7;
   localparam logic        ACT_FILTER   = 1'b0;
   localparam logic        ACT_CLEAR    = 1'b1;
   localparam longint      SAT_HI       = 64'sd2147483647;
   localparam longint      SAT_LO       = -64'sd2147483648;

   typedef struct {
      logic signed [19:0] sample;
      logic [3:0]         voice;
      logic               channel;
   } filter_out_type;

   // one row of the directed table: a register write or an item
   typedef struct {
      bit                 is_csr;
      logic [2:0]         reg_index;
      logic [31:0]        reg_value;
      logic               action;
      logic [3:0]         voice;
      logic               channel;
      logic signed [23:0] sample;
      logic signed [23:0] cutoff_cv;
      logic signed [23:0] resonance_cv;
      bit                 typed;
      logic signed [19:0] typed_out;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_action = 1'b0;
   logic [3:0]         req_voice = '0;
   logic               req_channel = 1'b0;
   logic signed [23:0] req_sample_in = '0;
   logic signed [23:0] req_cutoff_cv = '0;
   logic signed [23:0] req_resonance_cv = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [19:0] rsp_sample_out;
   logic [3:0]         rsp_voice_out;
   logic               rsp_channel_out;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]  csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   resonant_four_stage_filter_core #(.VOICES(VOICE_COUNT)) u_top (.*);

   always #6 clock = ~clock;

   // mirrored registers and stored stages
   logic [16:0]        cfg_cutoff_base, cfg_res_base, cfg_cutoff_depth, cfg_res_depth;
   logic [18:0]        cfg_rate_scale;
   logic               cfg_high_pass, cfg_four_pole;
   logic signed [31:0] stage_mem [4][VOICE_COUNT][2];

   filter_out_type     pending_out [$];
   int                 error_count = 0;
   int                 items_sent = 0;
   int                 results_seen = 0;
   int                 clears_sent = 0;
   int                 idle_cycles = 0;
   int                 sender_idle_pct = 0;
   int                 receiver_stall_pct = 0;
   bit                 run_done = 1'b0;

   function automatic longint clamp_range(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint int_root(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 << 32;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // floor(d * f / 2^16) bounded to the feedback range without overflow
   function automatic longint feedback_term(longint d, longint f);
      longint ud, uf, prod;
      bit     neg;
      ud  = d < 0 ? -d : d;
      uf  = f < 0 ? -f : f;
      neg = (d < 0) != (f < 0);
      if (uf != 0 && ud > (64'sd1 << 33) / uf) return neg ? -FB_LIMIT : FB_LIMIT;
      prod = ud * uf;
      if (neg) prod = -prod;
      return clamp_range(prod >>> 16, -FB_LIMIT, FB_LIMIT);
   endfunction

   // next filter output of one item, updates stored stages
   function automatic logic signed [19:0] filter_predict(logic act, logic [3:0] v, logic ch,
         logic signed [23:0] xin, logic signed [23:0] ccv, logic signed [23:0] rcv);
      longint c2, cut, res, q, fb, p, x, tap, y;
      longint s [4];
      if (act == ACT_CLEAR) begin
         for (int k = 0; k < 4; k++) begin
            stage_mem[k][v][0] = '0;
            stage_mem[k][v][1] = '0;
         end
         return '0;
      end
      x  = longint'(xin);
      c2 = ((longint'(cfg_cutoff_base) * longint'(cfg_cutoff_base)) >>> 16)
         + ((longint'(cfg_cutoff_depth) * longint'(ccv)) >>> 16);
      c2 = clamp_range((c2 * longint'(cfg_rate_scale)) >>> 16, 0, longint'(CUT2_MAX));
      cut = int_root(c2 << 16);
      res = longint'(cfg_res_base) + ((longint'(cfg_res_depth) * longint'(rcv)) >>> 16);
      q   = clamp_range((res * 65536) / (65536 - cut), SAT_LO, SAT_HI);
      fb  = clamp_range(res + q, SAT_LO, SAT_HI);
      for (int k = 0; k < 4; k++) s[k] = longint'(stage_mem[k][v][ch]);
      p = feedback_term(s[0] - s[1], fb);
      s[0] = clamp_range(s[0] + ((cut * (x - s[0] + p)) >>> 16), SAT_LO, SAT_HI);
      for (int k = 1; k < 4; k++)
         s[k] = clamp_range(s[k] + ((cut * (s[k-1] - s[k])) >>> 16), SAT_LO, SAT_HI);
      for (int k = 0; k < 4; k++) stage_mem[k][v][ch] = s[k][31:0];
      tap = cfg_four_pole ? s[3] : s[1];
      y   = cfg_high_pass ? x - tap : tap;
      return 20'(clamp_range(y, -OUT_LIMIT, OUT_LIMIT));
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
   endtask

   // register write, setup then access phase
   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = CSR_AW'(idx) << 2;
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      case (idx)
         REG_CUTOFF_BASE:    cfg_cutoff_base  = value[16:0];
         REG_RESONANCE_BASE: cfg_res_base     = value[16:0];
         REG_CUTOFF_DEPTH:   cfg_cutoff_depth = value[16:0];
         REG_RES_DEPTH:      cfg_res_depth    = value[16:0];
         REG_RATE_SCALE:     cfg_rate_scale   = value[18:0];
         REG_HIGH_PASS:      cfg_high_pass    = value[0];
         REG_FOUR_POLE:      cfg_four_pole    = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // wait until every result is in, then let the block settle
   task automatic drain_results();
      while (pending_out.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_setting(logic [31:0] cb, logic [31:0] rb, logic [31:0] cd,
         logic [31:0] rd, logic [31:0] rs, logic [31:0] hp, logic [31:0] fp);
      drain_results();
      csr_write(REG_CUTOFF_BASE, cb);
      csr_write(REG_RESONANCE_BASE, rb);
      csr_write(REG_CUTOFF_DEPTH, cd);
      csr_write(REG_RES_DEPTH, rd);
      csr_write(REG_RATE_SCALE, rs);
      csr_write(REG_HIGH_PASS, hp);
      csr_write(REG_FOUR_POLE, fp);
   endtask

   // offer one item, hold it until accepted, queue its expected result
   task automatic send_item(logic act, logic [3:0] v, logic ch, logic signed [23:0] xin,
         logic signed [23:0] ccv, logic signed [23:0] rcv, bit typed,
         logic signed [19:0] typed_out);
      filter_out_type e;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_action       = act;
      req_voice        = v;
      req_channel      = ch;
      req_sample_in    = xin;
      req_cutoff_cv    = ccv;
      req_resonance_cv = rcv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      e.sample  = filter_predict(act, v, ch, xin, ccv, rcv);
      if (typed) e.sample = typed_out;
      e.voice   = v;
      e.channel = ch;
      pending_out = {pending_out, e};
      items_sent++;
      if (act == ACT_CLEAR) clears_sent++;
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   // result checking against the oldest expectation
   always @(posedge clock) begin
      filter_out_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_out.size() == 0) begin
            report_mismatch("unexpected result, voice", rsp_voice_out, -1);
         end else begin
            e = pending_out.pop_front();
            if (rsp_sample_out !== e.sample)
               report_mismatch("sample_out", rsp_sample_out, e.sample);
            if (rsp_voice_out !== e.voice)
               report_mismatch("voice_out", rsp_voice_out, e.voice);
            if (rsp_channel_out !== e.channel)
               report_mismatch("channel_out", rsp_channel_out, e.channel);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d quiet cycles", idle_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic signed [23:0] pick_signal(int wide_pct);
      if ($urandom_range(99) < wide_pct) return 24'($urandom);
      return $signed(24'($urandom_range(0, 262143))) - 24'sd131072;
   endfunction

   directed_row_type directed [$];

   function automatic directed_row_type item_row(logic act, logic [3:0] v, logic ch,
         logic signed [23:0] xin, logic signed [23:0] ccv, logic signed [23:0] rcv,
         bit typed, logic signed [19:0] want);
      directed_row_type r;
      r = '{default: '0};
      r.action = act; r.voice = v; r.channel = ch;
      r.sample = xin; r.cutoff_cv = ccv; r.resonance_cv = rcv;
      r.typed = typed; r.typed_out = want;
      return r;
   endfunction

   function automatic directed_row_type csr_row(logic [2:0] idx, logic [31:0] value);
      directed_row_type r;
      r = '{default: '0};
      r.is_csr = 1'b1; r.reg_index = idx; r.reg_value = value;
      return r;
   endfunction

   // append one row to the directed table
   function automatic void add_row(directed_row_type r);
      directed = {directed, r};
   endfunction

   initial begin
      directed_row_type r;
      logic [3:0]       v;
      int               per_phase;

      cfg_cutoff_base  = '0;
      cfg_res_base     = '0;
      cfg_cutoff_depth = '0;
      cfg_res_depth    = '0;
      cfg_rate_scale   = RATE_RESET;
      cfg_high_pass    = 1'b0;
      cfg_four_pole    = 1'b0;
      foreach (stage_mem[k, i, c]) stage_mem[k][i][c] = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // after reset the cutoff is zero, so low-pass output stays at zero
      add_row(item_row(ACT_FILTER, 4'd0, 1'b0, 24'sh7FFFFF, 24'sd0, 24'sd0, 1, 0));
      add_row(item_row(ACT_FILTER, 4'd15, 1'b1, -24'sh800000, 24'sh7FFFFF,
                       -24'sh800000, 1, 0));
      add_row(item_row(ACT_CLEAR, 4'd3, 1'b1, 24'sh7FFFFF, 0, 0, 1, 0));
      // high-pass with zero cutoff passes the input, clamped to +/-5
      add_row(csr_row(REG_HIGH_PASS, 32'd1));
      add_row(item_row(ACT_FILTER, 4'd1, 1'b0, 24'sh7FFFFF, 0, 0, 1, 327680));
      add_row(item_row(ACT_FILTER, 4'd1, 1'b1, -24'sh800000, 0, 0, 1, -327680));
      add_row(item_row(ACT_FILTER, 4'd2, 1'b0, 24'sd12345, 0, 0, 1, 12345));
      // full cutoff, resonance and four-pole output; deep modulation comes further down
      add_row(csr_row(REG_CUTOFF_BASE, 32'd65536));
      add_row(csr_row(REG_RESONANCE_BASE, 32'd32768));
      add_row(csr_row(REG_FOUR_POLE, 32'd1));
      add_row(item_row(ACT_FILTER, 4'd5, 1'b0, 24'sd65536, 0, 0, 0, 0));
      add_row(item_row(ACT_FILTER, 4'd5, 1'b0, -24'sd65536, 24'sh7FFFFF, 0, 0, 0));
      add_row(item_row(ACT_FILTER, 4'd5, 1'b1, 24'sh7FFFFF, -24'sh800000, 0, 0, 0));
      // write to an index past the list is ignored
      add_row(csr_row(REG_SPARE, 32'hFFFF_FFFF));
      add_row(item_row(ACT_CLEAR, 4'd5, 1'b0, 0, 0, 0, 1, 0));
      add_row(item_row(ACT_FILTER, 4'd5, 1'b1, 24'sd200000, 0, 0, 0, 0));
      add_row(csr_row(REG_CUTOFF_DEPTH, 32'd65536));
      add_row(csr_row(REG_RES_DEPTH, 32'd65536));
      add_row(csr_row(REG_RATE_SCALE, 32'd524287));
      add_row(csr_row(REG_HIGH_PASS, 32'd0));
      add_row(item_row(ACT_FILTER, 4'd7, 1'b0, 24'sh7FFFFF, 24'sh7FFFFF,
                       24'sh7FFFFF, 0, 0));
      add_row(item_row(ACT_FILTER, 4'd7, 1'b0, -24'sh800000, -24'sh800000,
                       -24'sh800000, 0, 0));
      add_row(item_row(ACT_FILTER, 4'd7, 1'b0, 24'sh7FFFFF, 24'sd0,
                       -24'sh800000, 0, 0));
      add_row(item_row(ACT_FILTER, 4'd7, 1'b0, 24'sd0, 24'sh7FFFFF,
                       24'sh7FFFFF, 0, 0));

      foreach (directed[i]) begin
         r = directed[i];
         if (r.is_csr) begin
            // withdraw the last item before the block goes idle again
            @(negedge clock);
            req_valid = 1'b0;
            drain_results();
            csr_write(r.reg_index, r.reg_value);
         end else begin
            send_item(r.action, r.voice, r.channel, r.sample, r.cutoff_cv,
                      r.resonance_cv, r.typed, r.typed_out);
         end
      end
      @(negedge clock);
      req_valid = 1'b0;

      // random part: one setting and one idle profile per phase
      per_phase = RANDOM_ITEMS / PHASES;
      for (int ph = 0; ph < PHASES; ph++) begin
         @(negedge clock);
         req_valid = 1'b0;
         case (ph)
            0: program_setting(65536, 65536, 65536, 65536, 524287, 1, 1);
            1: program_setting(0, 0, 0, 0, 0, 0, 0);
            2: program_setting($urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom);
            default: program_setting($urandom_range(65536), $urandom_range(65536),
                                     $urandom_range(32768), $urandom_range(16384),
                                     $urandom_range(32768, 98304), $urandom_range(1),
                                     $urandom_range(1));
         endcase
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
            default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
         endcase
         for (int n = 0; n < per_phase; n++) begin
            // hold off mid-phase until the pipeline is empty
            if (n == per_phase / 2) begin
               @(negedge clock);
               req_valid = 1'b0;
               while (pending_out.size() != 0) @(posedge clock);
            end
            v = $urandom_range(3) == 0 ? 4'($urandom_range(15)) : 4'($urandom_range(1));
            send_item($urandom_range(99) < 5 ? ACT_CLEAR : ACT_FILTER, v,
                      1'($urandom_range(1)), pick_signal(10), pick_signal(15),
                      pick_signal(15), 0, 0);
         end
      end
      @(negedge clock);
      req_valid = 1'b0;

      while (pending_out.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      run_done = 1'b1;
      $display("covered %0d items (%0d clears) and %0d results over %0d register settings",
               items_sent, clears_sent, results_seen, PHASES + 1);
      $display("with sender gaps, receiver stalls, a drain pause and %0d mismatches",
               error_count);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
